// ===== sv/fltw_pkg.sv =====
// Shared constants, types and helper functions of the four-level page-table walker.
`default_nettype none

package fltw_pkg;

   localparam int MEM_WORDS     = 4096;
   localparam int TABLE_ENTRIES = 512;

   localparam int WORD_AW = $clog2(MEM_WORDS);
   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int DATA_W  = 64;
   localparam int WIDX_W  = 12;
   localparam int ROOT_W  = 52;
   localparam int VA_W    = 48;
   localparam int PA_W    = 53;
   localparam int BASE_W  = 40;
   localparam int PAGE_W  = 12;
   localparam int HUGE_W  = 21;

   localparam int PRESENT_BIT = 0;
   localparam int HUGE_BIT    = 7;

   // Queue depths must be powers of two so that the pointers wrap by themselves.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CW    = $clog2(RSPQ_DEPTH + 1);

   typedef logic [1:0] level_type;
   localparam level_type LVL_PML4 = 2'd0;
   localparam level_type LVL_PDPT = 2'd1;
   localparam level_type LVL_PD   = 2'd2;
   localparam level_type LVL_PT   = 2'd3;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_WALK  = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [WIDX_W-1:0]   word_index;
      logic [DATA_W-1:0]   word_data;
      logic [BASE_W-1:0]   root_base;
      logic [VA_W-1:0]     virt_addr;
   } cmd_type;

   typedef struct packed {
      logic [PA_W-1:0] phys_addr;
      logic            mapped;
      logic            huge_page;
      level_type       fault_level;
   } rsp_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   // Word address of an entry: table base in 4 KiB units followed by the index,
   // taken modulo the memory size.
   function automatic logic [WORD_AW-1:0] word_addr(input logic [BASE_W-1:0] base,
                                                    input logic [IDX_W-1:0]  idx);
      logic [BASE_W+IDX_W-1:0] full;
      full = {base, idx};
      return full[WORD_AW-1:0];
   endfunction

   function automatic logic [WORD_AW-1:0] write_addr(input logic [WIDX_W-1:0] wi);
      logic [WIDX_W+WORD_AW-1:0] ext;
      ext = {{WORD_AW{1'b0}}, wi};
      return ext[WORD_AW-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input level_type       lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         LVL_PML4: idx = va[47:39];
         LVL_PDPT: idx = va[38:30];
         LVL_PD:   idx = va[29:21];
         LVL_PT:   idx = va[20:12];
         default:  idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== sv/fltw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fltw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/fltw_front.sv =====
// Front end: takes request transactions, classifies them and queues them for the walker.
`default_nettype none

module fltw_front
   import fltw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic                req_mode,
   input  wire logic [WIDX_W-1:0]   req_word_index,
   input  wire logic [DATA_W-1:0]   req_word_data,
   input  wire logic [ROOT_W-1:0]   req_root_addr,
   input  wire logic [VA_W-1:0]     req_virt_addr,
   output logic                     cmd_valid,
   output cmd_type                  cmd,
   input  wire back_ctl_type        back_ctl
);

   cmd_type              q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0]   cnt_ff, cnt_in;
   cmd_type              new_cmd;
   logic                 push_ok;
   logic                 pop_ok;

   // The walker cannot take anything while it is sweeping the table memory clear.
   assign req_full  = (cnt_ff == CMDQ_CW'(CMDQ_DEPTH)) || back_ctl.clearing;
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != '0);
   assign pop_ok    = back_ctl.pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op         = op_type'(req_mode);
      new_cmd.word_index = req_word_index;
      new_cmd.word_data  = req_word_data;
      new_cmd.root_base  = req_root_addr[ROOT_W-1:PAGE_W];
      new_cmd.virt_addr  = req_virt_addr;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== sv/fltw_back.sv =====
// Back end: clears the table memory, executes entry writes and walks, and queues results.
`default_nettype none

module fltw_back
   import fltw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   input  wire cmd_type       cmd,
   output back_ctl_type       back_ctl,
   input  wire logic          rsp_pop,
   output logic               rsp_empty,
   output rsp_type            rsp
);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_LOOK   = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   level_type            level_ff, level_in;
   logic [WORD_AW-1:0]   clr_ff, clr_in;
   logic [VA_W-1:0]      va_ff, va_in;
   rsp_type              res_ff, res_in;

   logic                 wr_en;
   logic [WORD_AW-1:0]   wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic                 rd_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic [DATA_W-1:0]    entry;
   logic                 res_push;

   rsp_type              rq_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]   rq_wr_ff, rq_wr_in;
   logic [RSPQ_AW-1:0]   rq_rd_ff, rq_rd_in;
   logic [RSPQ_CW-1:0]   rq_cnt_ff, rq_cnt_in;
   logic                 rq_full;
   logic                 rq_pop;

   fltw_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (entry)
   );

   assign rq_full = (rq_cnt_ff == RSPQ_CW'(RSPQ_DEPTH));

   always_comb begin
      state_in          = state_ff;
      level_in          = level_ff;
      clr_in            = clr_ff;
      va_in             = va_ff;
      res_in            = res_ff;
      wr_en             = 1'b0;
      wr_addr           = clr_ff;
      wr_data           = '0;
      rd_en             = 1'b0;
      rd_addr           = word_addr(cmd.root_base, va_index(cmd.virt_addr, LVL_PML4));
      res_push          = 1'b0;
      back_ctl.pop      = 1'b0;
      back_ctl.clearing = (state_ff == S_CLEAR);
      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               back_ctl.pop = 1'b1;
               if (cmd.op == OP_WRITE) begin
                  wr_en    = 1'b1;
                  wr_addr  = write_addr(cmd.word_index);
                  wr_data  = cmd.word_data;
                  res_in   = '0;
                  state_in = S_RESULT;
               end else begin
                  rd_en    = 1'b1;
                  va_in    = cmd.virt_addr;
                  level_in = LVL_PML4;
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            // The entry of the current level has just come out of the memory.
            if (!entry[PRESENT_BIT]) begin
               res_in.phys_addr   = '0;
               res_in.mapped      = 1'b0;
               res_in.huge_page   = 1'b0;
               res_in.fault_level = level_ff;
               state_in           = S_RESULT;
            end else if (level_ff == LVL_PD && entry[HUGE_BIT]) begin
               res_in.phys_addr   = PA_W'({entry[ROOT_W-1:HUGE_W], va_ff[HUGE_W-1:0]});
               res_in.mapped      = 1'b1;
               res_in.huge_page   = 1'b1;
               res_in.fault_level = LVL_PML4;
               state_in           = S_RESULT;
            end else if (level_ff == LVL_PT) begin
               res_in.phys_addr   = PA_W'({entry[ROOT_W-1:PAGE_W], va_ff[PAGE_W-1:0]});
               res_in.mapped      = 1'b1;
               res_in.huge_page   = 1'b0;
               res_in.fault_level = LVL_PML4;
               state_in           = S_RESULT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = word_addr(entry[ROOT_W-1:PAGE_W], va_index(va_ff, level_ff + 1'b1));
               level_in = level_ff + 1'b1;
            end
         end
         S_RESULT: begin
            if (!rq_full) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         level_ff <= LVL_PML4;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff  <= va_in;
      res_ff <= res_in;
   end

   // Result queue towards the consumer.
   assign rq_pop    = rsp_pop && (rq_cnt_ff != '0);
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rsp       = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in  = rq_wr_ff;
      rq_rd_in  = rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (res_push) begin
         rq_wr_in = rq_wr_ff + 1'b1;
      end
      if (rq_pop) begin
         rq_rd_in = rq_rd_ff + 1'b1;
      end
      if (res_push && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rq_pop && !res_push) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res_ff;
      end
   end

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!back_ctl.pop && !res_push))
      else $error("walker took work during the clearing pass");

   a_rq_bounded: assert property (@(posedge clock) disable iff (reset)
      rq_cnt_ff <= RSPQ_CW'(RSPQ_DEPTH))
      else $error("result queue overfilled");

   a_push_returns_idle: assert property (@(posedge clock) disable iff (reset)
      res_push |=> (state_ff == S_IDLE))
      else $error("walker did not return to idle after a result");

   a_walk_ends_at_leaf: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK && level_ff == LVL_PT) |=> (state_ff != S_LOOK))
      else $error("walk continued past the last level");

endmodule

`default_nettype wire

// ===== sv/four_level_page_table_walk.sv =====
// Top level of the four-level page-table walker: request front end and walker back end.
// A translation reads one table entry per level until it finds a leaf or a missing
// entry, so a fault or a huge page ends it early; an entry write goes straight to its result.
// The walker takes a new request only after the result of the last one is queued, and
// the four dependent table reads of a full walk share the single memory read port.
// After reset the table memory is swept to zero, one word a cycle, and req_full stays high
// until the sweep is done.
`default_nettype none

module four_level_page_table_walk
   import fltw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic                req_mode,
   input  wire logic [WIDX_W-1:0]   req_word_index,
   input  wire logic [DATA_W-1:0]   req_word_data,
   input  wire logic [ROOT_W-1:0]   req_root_addr,
   input  wire logic [VA_W-1:0]     req_virt_addr,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [PA_W-1:0]          rsp_phys_addr,
   output logic                     rsp_mapped,
   output logic                     rsp_huge_page,
   output logic [1:0]               rsp_fault_level
);

   logic          cmd_valid;
   cmd_type       cmd;
   back_ctl_type  back_ctl;
   rsp_type       rsp;

   fltw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_root_addr  (req_root_addr),
      .req_virt_addr  (req_virt_addr),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .back_ctl       (back_ctl)
   );

   fltw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .back_ctl  (back_ctl),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_phys_addr   = rsp.phys_addr;
   assign rsp_mapped      = rsp.mapped;
   assign rsp_huge_page   = rsp.huge_page;
   assign rsp_fault_level = rsp.fault_level;

endmodule

`default_nettype wire

// ===== dv/page_walk_checker.sv =====
// Watches both channels of the page-table walker, predicts each result and compares it.
module page_walk_checker
   import fltw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire logic              req_full,
   input  wire logic              req_mode,
   input  wire logic [WIDX_W-1:0] req_word_index,
   input  wire logic [DATA_W-1:0] req_word_data,
   input  wire logic [ROOT_W-1:0] req_root_addr,
   input  wire logic [VA_W-1:0]   req_virt_addr,
   input  wire logic              rsp_empty,
   input  wire logic              rsp_pop,
   input  wire logic [PA_W-1:0]   rsp_phys_addr,
   input  wire logic              rsp_mapped,
   input  wire logic              rsp_huge_page,
   input  wire logic [1:0]        rsp_fault_level,
   output int unsigned            error_count,
   output int unsigned            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] PAGE_MASK  = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] HUGE_MASK  = 64'h000F_FFFF_FFE0_0000;
   localparam logic [63:0] PAGE_OFFS  = 64'h0000_0000_0000_0FFF;
   localparam logic [63:0] HUGE_OFFS  = 64'h0000_0000_001F_FFFF;

   logic [DATA_W-1:0] table_copy [MEM_WORDS];
   rsp_type           expected_rsp [$];
   int unsigned       mismatches = 0;

   // Walks the shadow copy of the table memory exactly as the hardware should.
   function automatic rsp_type predict_walk(input logic [ROOT_W-1:0] root,
                                            input logic [VA_W-1:0]   va);
      rsp_type          res;
      logic [63:0]      tbl;
      logic [63:0]      entry;
      logic [63:0]      word;
      logic [63:0]      pa;
      logic [63:0]      va_ext;
      logic [IDX_W-1:0] idx;
      int               lvl;
      res    = '0;
      entry  = '0;
      va_ext = {16'b0, va};
      tbl    = {12'b0, root} & PAGE_MASK;
      for (lvl = 0; lvl < 4; lvl++) begin
         idx   = va[39 - 9 * lvl +: IDX_W];
         word  = (tbl >> 3) + idx;
         entry = table_copy[word % MEM_WORDS];
         if (!entry[PRESENT_BIT]) begin
            res.fault_level = level_type'(lvl);
            return res;
         end
         if (lvl == LVL_PD && entry[HUGE_BIT]) begin
            pa              = (entry & HUGE_MASK) | (va_ext & HUGE_OFFS);
            res.phys_addr   = pa[PA_W-1:0];
            res.mapped      = 1'b1;
            res.huge_page   = 1'b1;
            return res;
         end
         tbl = entry & PAGE_MASK;
      end
      pa            = (entry & PAGE_MASK) | (va_ext & PAGE_OFFS);
      res.phys_addr = pa[PA_W-1:0];
      res.mapped    = 1'b1;
      return res;
   endfunction

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MEM_WORDS; i++) table_copy[i] = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t ns: transaction with nothing expected, expected none, got %h",
                        $time, rsp_phys_addr);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_phys_addr !== want.phys_addr)
                  note_mismatch("phys_addr", want.phys_addr, rsp_phys_addr);
               if (rsp_mapped !== want.mapped)
                  note_mismatch("mapped", want.mapped, rsp_mapped);
               if (rsp_huge_page !== want.huge_page)
                  note_mismatch("huge_page", want.huge_page, rsp_huge_page);
               if (rsp_fault_level !== want.fault_level)
                  note_mismatch("fault_level", want.fault_level, rsp_fault_level);
            end
         end
         // A result can never come out in the cycle its request goes in, so the
         // result side is handled first.
         if (req_push && !req_full) begin
            if (op_type'(req_mode) == OP_WRITE) begin
               table_copy[req_word_index % MEM_WORDS] = req_word_data;
               expected_rsp.push_back('0);
            end else begin
               expected_rsp.push_back(predict_walk(req_root_addr, req_virt_addr));
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_rsp.size();
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the page-table walker: clock, reset, stimulus and the final verdict.
module tb
   import fltw_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 1800;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_mode;
   logic [WIDX_W-1:0] req_word_index;
   logic [DATA_W-1:0] req_word_data;
   logic [ROOT_W-1:0] req_root_addr;
   logic [VA_W-1:0]   req_virt_addr;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [PA_W-1:0]   rsp_phys_addr;
   logic              rsp_mapped;
   logic              rsp_huge_page;
   logic [1:0]        rsp_fault_level;

   int unsigned fail_count;
   int unsigned pending_rsp;
   int unsigned items_sent = 0;
   bit          hold_off_req = 1'b0;
   bit          no_gaps = 1'b0;
   bit          src_calm = 1'b0;

   four_level_page_table_walk u_dut (.*);

   page_walk_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_word_index  (req_word_index),
      .req_word_data   (req_word_data),
      .req_root_addr   (req_root_addr),
      .req_virt_addr   (req_virt_addr),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_phys_addr   (rsp_phys_addr),
      .rsp_mapped      (rsp_mapped),
      .rsp_huge_page   (rsp_huge_page),
      .rsp_fault_level (rsp_fault_level),
      .error_count     (fail_count),
      .pending_count   (pending_rsp)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_W-1:0] table_entry(input logic [2:0] next_tbl,
                                                     input bit present, input bit huge);
      logic [DATA_W-1:0] e;
      e              = {$urandom, $urandom};
      e[14:12]       = next_tbl;
      e[PRESENT_BIT] = present;
      e[HUGE_BIT]    = huge;
      return e;
   endfunction

   task automatic issue(input op_type op, input logic [WIDX_W-1:0] widx,
                        input logic [DATA_W-1:0] wdata, input logic [ROOT_W-1:0] root,
                        input logic [VA_W-1:0] va);
      int unsigned gap;
      req_mode       <= op;
      req_word_index <= widx;
      req_word_data  <= wdata;
      req_root_addr  <= root;
      req_virt_addr  <= va;
      req_push       <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
      gap = (no_gaps || src_calm) ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_word(input logic [WIDX_W-1:0] widx, input logic [DATA_W-1:0] wdata);
      issue(OP_WRITE, widx, wdata, ROOT_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}));
   endtask

   task automatic translate(input logic [ROOT_W-1:0] root, input logic [VA_W-1:0] va);
      issue(OP_WALK, WIDX_W'($urandom), {$urandom, $urandom}, root, va);
   endtask

   // Lays down the entries of one walk with random content and then translates
   // through them; some chains fault on purpose or keep a stale entry.
   task automatic walk_chain();
      logic [ROOT_W-1:0] root;
      logic [VA_W-1:0]   va;
      logic [2:0]        tbl [5];
      logic [IDX_W-1:0]  idx;
      int                fault_lvl;
      int                last_lvl;
      int                lvl;
      bit                huge_leaf;
      root   = ROOT_W'({$urandom, $urandom});
      va     = VA_W'({$urandom, $urandom});
      tbl[0] = root[14:12];
      for (lvl = 1; lvl < 5; lvl++) tbl[lvl] = 3'($urandom);
      fault_lvl = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(0, 3);
      huge_leaf = ($urandom_range(0, 2) == 0);
      last_lvl  = huge_leaf ? 2 : 3;
      for (lvl = 0; lvl <= last_lvl && lvl <= fault_lvl; lvl++) begin
         idx = va[39 - 9 * lvl +: IDX_W];
         if ($urandom_range(0, 29) != 0) begin
            write_word({tbl[lvl], idx},
                       table_entry(tbl[lvl + 1], lvl != fault_lvl,
                                   (lvl == 2) ? huge_leaf : bit'($urandom_range(0, 1))));
         end
         if ($urandom_range(0, 19) == 0) write_word(WIDX_W'($urandom), {$urandom, $urandom});
      end
      translate(root, va);
      if ($urandom_range(0, 3) == 0) begin
         va[20:0] = 21'($urandom);
         translate(root, va);
      end
   endtask

   // The receiver pops with random gaps and, once asked, holds off for a long stretch.
   initial begin : rsp_sink
      int unsigned idle;
      bit          sink_calm;
      idle      = 0;
      sink_calm = 1'b0;
      rsp_pop  <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            idle         = HOLD_CYCLES;
         end
         if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
         if (idle == 0 && !sink_calm && $urandom_range(0, 3) == 0) idle = pick_gap();
         if (idle > 0) begin
            rsp_pop <= 1'b0;
            idle--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int unsigned r;
      bit          held;
      bit          paused;
      held            = 1'b0;
      paused          = 1'b0;
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_mode       <= OP_WRITE;
      req_word_index <= '0;
      req_word_data  <= '0;
      req_root_addr  <= '0;
      req_virt_addr  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Freshly cleared memory faults at the top level.
      translate('0, '0);
      translate('1, '1);
      write_word('0, '0);
      // An all-ones word at the last index makes every level point back at itself,
      // and the set huge bit ends the walk on a 2 MiB page.
      write_word('1, '1);
      translate('1, '1);
      write_word('1, ~(64'b1 << HUGE_BIT));
      translate('1, '1);
      // A clean chain through tables one to four, with huge bits where they are ignored.
      write_word(12'd512, table_entry(3'd2, 1'b1, 1'b0));
      write_word(12'd1024, table_entry(3'd3, 1'b1, 1'b1));
      write_word(12'd1536, table_entry(3'd4, 1'b1, 1'b0));
      write_word(12'd2048, table_entry(3'd5, 1'b1, 1'b1));
      translate(52'h0_0000_0000_1000, 48'h0000_0000_0abc);
      // Knock out the chain from the bottom up so that each level faults in turn.
      write_word(12'd2048, table_entry(3'd5, 1'b0, 1'b1));
      translate(52'h0_0000_0000_1000, 48'h0000_0000_0fff);
      write_word(12'd1536, table_entry(3'd4, 1'b0, 1'b0));
      translate(52'h0_0000_0000_1000, 48'h0000_0000_0000);
      write_word(12'd1024, table_entry(3'd3, 1'b0, 1'b1));
      translate(52'h0_0000_0000_1000, 48'h0000_0000_0123);
      write_word(12'd512, table_entry(3'd2, 1'b0, 1'b0));
      translate(52'hF_FFFF_FFFF_9FFF, 48'h0000_0000_0456);
      // Huge leaf at the third level with address bits 20..12 set in the entry.
      write_word(12'd512, table_entry(3'd2, 1'b1, 1'b0));
      write_word(12'd1024, table_entry(3'd3, 1'b1, 1'b0));
      write_word(12'd1536, table_entry(3'd4, 1'b1, 1'b1) | 64'h0000_0000_001F_F000);
      translate(52'h0_0000_0000_1000, 48'h0000_001F_FFFF);

      while (items_sent < ITEM_TARGET + 25) begin
         if (!held && items_sent >= 600) begin
            // Starve the result side while requests keep coming, so the block backs up.
            held         = 1'b1;
            hold_off_req = 1'b1;
            no_gaps      = 1'b1;
            repeat (12) walk_chain();
            no_gaps = 1'b0;
         end
         if (!paused && items_sent >= 1200) begin
            paused    = 1'b1;
            req_push <= 1'b0;
            @(posedge clock);
            while (pending_rsp != 0) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 75) walk_chain();
         else if (r < 90) write_word(WIDX_W'($urandom), {$urandom, $urandom});
         else translate(ROOT_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}));
      end

      req_push <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
